// ----- sv/tef_pkg.sv -----
// Touch event filter: shared constants, codes and types.
// No dependencies.
`default_nettype none

package tef_pkg;

    localparam int SLOT_BITS      = 5;
    localparam int TIME_BITS      = 32;
    localparam int SLOP_BITS      = 8;
    localparam int TIMEOUT_BITS   = 16;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam int DEF_SLOTS      = 32;
    localparam int DEF_COORD_BITS = 12;

    localparam logic [SLOP_BITS-1:0]    SLOP_RESET    = 8'd1;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd75;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOP    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_MOVE = 2'd2;
    localparam logic [1:0] EV_LIFT = 2'd3;

    localparam logic [1:0] KIND_BIRTH = 2'd0;
    localparam logic [1:0] KIND_DEATH = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;

    typedef struct packed {
        logic [SLOP_BITS-1:0]    slop;
        logic [TIMEOUT_BITS-1:0] timeout;
    } tef_cfg_t;

    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
    } tef_ram_ctl_t;

endpackage

`default_nettype wire

// ----- sv/tef_in_if.sv -----
// Touch event filter: input channel (touch reports, status words, ticks).
// Depends on tef_pkg.
`default_nettype none

interface tef_in_if
    import tef_pkg::*;
#(
    parameter int CW = DEF_COORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [SLOT_BITS-1:0] slot;
    logic [1:0]           event_kind;
    logic [CW-1:0]        pos_x;
    logic [CW-1:0]        pos_y;
    logic [TIME_BITS-1:0] now_ms;

    modport source (output valid, opcode, slot, event_kind, pos_x, pos_y, now_ms,
                    input ready);
    modport sink   (input valid, opcode, slot, event_kind, pos_x, pos_y, now_ms,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/tef_out_if.sv -----
// Touch event filter: output channel (birth, move and death events).
// Depends on tef_pkg.
`default_nettype none

interface tef_out_if
    import tef_pkg::*;
#(
    parameter int CW = DEF_COORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [SLOT_BITS-1:0] out_slot;
    logic [1:0]           out_kind;
    logic [CW-1:0]        out_x;
    logic [CW-1:0]        out_y;
    logic [TIME_BITS-1:0] out_time;
    logic                 last;

    modport source (output valid, out_slot, out_kind, out_x, out_y, out_time, last,
                    input ready);
    modport sink   (input valid, out_slot, out_kind, out_x, out_y, out_time, last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/touch_event_filter_top.sv -----
// Touch event filter, top level.
// Report: accept with slot read, then modify/write back and emit any event.
// Tick after timeout: one slot memory read/write per cycle while output is free.
// Status words, ignored ticks and out-of-range slots: no event.
// Reset clears live flags and loads config defaults; slot memory is not cleared.
// Depends on tef_pkg, tef_in_if, tef_out_if, tef_cfg_regs, tef_slot_ram.
`default_nettype none

module touch_event_filter_top
    import tef_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    tef_in_if.sink                        in_ch,
    tef_out_if.source                     out_ch,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = COORD_BITS;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic [TIME_BITS-1:0] ev;
        logic [TIME_BITS-1:0] rcv;
        logic [TIME_BITS-1:0] snd;
    } entry_t;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    tef_cfg_t     cfg;
    tef_ram_ctl_t ram_ctl;
    entry_t       rd_ent;
    entry_t       wr_ent;

    state_t               state_reg,    state_next;
    logic                 tick_reg,     tick_next;
    logic [AW-1:0]        addr_reg,     addr_next;
    logic [1:0]           ek_reg,       ek_next;
    logic [CW-1:0]        x_reg,        x_next;
    logic [CW-1:0]        y_reg,        y_next;
    logic [TIME_BITS-1:0] now_reg,      now_next;
    logic [TIME_BITS-1:0] latest_reg,   latest_next;
    logic [SLOTS-1:0]     live_reg,     live_next;
    logic                 ov_reg,       ov_next;
    logic [SLOT_BITS-1:0] oslot_reg,    oslot_next;
    logic [1:0]           okind_reg,    okind_next;
    logic [CW-1:0]        ox_reg,       ox_next;
    logic [CW-1:0]        oy_reg,       oy_next;
    logic [TIME_BITS-1:0] otime_reg,    otime_next;
    logic                 olast_reg,    olast_next;

    logic                 slot_ok;
    logic                 quiet;
    logic                 can_go;
    logic                 live_s;
    logic [CW-1:0]        dx;
    logic [CW-1:0]        dy;
    logic                 far;
    logic                 do_birth;
    logic                 do_move;
    logic                 do_death;
    logic [TIME_BITS-1:0] since_send;
    logic [TIME_BITS-1:0] twice;
    logic                 any_above;

    tef_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tef_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .DW    ($bits(entry_t))
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_data (wr_ent),
        .rd_data (rd_ent)
    );

    assign slot_ok = {1'b0, in_ch.slot} < (SLOT_BITS + 1)'(SLOTS);
    assign quiet   = (in_ch.now_ms - latest_reg) > {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, cfg.timeout};
    assign can_go  = !ov_reg || out_ch.ready;
    assign live_s  = live_reg[addr_reg];

    assign dx  = (rd_ent.x > x_reg) ? rd_ent.x - x_reg : x_reg - rd_ent.x;
    assign dy  = (rd_ent.y > y_reg) ? rd_ent.y - y_reg : y_reg - rd_ent.y;
    assign far = (dx > CW'(cfg.slop)) || (dy > CW'(cfg.slop));

    assign do_birth = (ek_reg == EV_DOWN) || ((ek_reg == EV_MOVE) && !live_s);
    assign do_move  = (ek_reg == EV_MOVE) && live_s && ((rd_ent.kind == KIND_BIRTH) || far);
    assign do_death = (ek_reg == EV_LIFT) && live_s;

    assign since_send = now_reg - rd_ent.snd;
    assign twice      = {{(TIME_BITS-TIMEOUT_BITS-1){1'b0}}, cfg.timeout, 1'b0};

    always_comb
    begin
        any_above = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (((AW + 1)'(j) > {1'b0, addr_reg}) && live_reg[j])
            begin
                any_above = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        addr_next   = addr_reg;
        ek_next     = ek_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        now_next    = now_reg;
        latest_next = latest_reg;
        live_next   = live_reg;
        ov_next     = ov_reg;
        oslot_next  = oslot_reg;
        okind_next  = okind_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        otime_next  = otime_reg;
        olast_next  = olast_reg;
        ram_ctl     = '0;
        wr_ent      = rd_ent;

        if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    ek_next  = in_ch.event_kind;
                    x_next   = in_ch.pos_x;
                    y_next   = in_ch.pos_y;
                    now_next = in_ch.now_ms;
                    if ((in_ch.opcode == OP_REPORT) && slot_ok)
                    begin
                        latest_next     = in_ch.now_ms;
                        addr_next       = in_ch.slot[AW-1:0];
                        tick_next       = 1'b0;
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = in_ch.slot;
                        state_next      = ST_EXEC;
                    end
                    else if ((in_ch.opcode == OP_TICK) && quiet && (|live_reg))
                    begin
                        addr_next       = '0;
                        tick_next       = 1'b1;
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = '0;
                        state_next      = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                if (can_go)
                begin
                    ram_ctl.wr_addr = SLOT_BITS'(addr_reg);
                    oslot_next      = SLOT_BITS'(addr_reg);
                    if (!tick_reg)
                    begin
                        ram_ctl.wr_en = 1'b1;
                        wr_ent.rcv    = now_reg;
                        if (do_birth || do_move)
                        begin
                            wr_ent.kind = do_birth ? KIND_BIRTH : KIND_MOVE;
                            wr_ent.x    = x_reg;
                            wr_ent.y    = y_reg;
                            wr_ent.ev   = now_reg;
                            wr_ent.snd  = now_reg;
                            live_next[addr_reg] = 1'b1;
                        end
                        else if (do_death)
                        begin
                            wr_ent.kind = KIND_DEATH;
                            wr_ent.snd  = now_reg;
                            live_next[addr_reg] = 1'b0;
                        end
                        if (do_birth || do_move || do_death)
                        begin
                            ov_next    = 1'b1;
                            okind_next = wr_ent.kind;
                            ox_next    = wr_ent.x;
                            oy_next    = wr_ent.y;
                            otime_next = wr_ent.ev;
                            olast_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (live_s)
                        begin
                            ram_ctl.wr_en = 1'b1;
                            wr_ent.kind   = KIND_DEATH;
                            wr_ent.ev     = (since_send > twice) ? rd_ent.rcv : rd_ent.ev;
                            wr_ent.snd    = rd_ent.rcv;
                            live_next[addr_reg] = 1'b0;
                            ov_next    = 1'b1;
                            okind_next = KIND_DEATH;
                            ox_next    = rd_ent.x;
                            oy_next    = rd_ent.y;
                            otime_next = wr_ent.ev;
                            olast_next = !any_above;
                        end
                        if (addr_reg == AW'(SLOTS - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            addr_next       = addr_reg + 1'b1;
                            ram_ctl.rd_en   = 1'b1;
                            ram_ctl.rd_addr = SLOT_BITS'(addr_reg + 1'b1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tick_reg   <= 1'b0;
            addr_reg   <= '0;
            ek_reg     <= EV_NONE;
            x_reg      <= '0;
            y_reg      <= '0;
            now_reg    <= '0;
            latest_reg <= '0;
            live_reg   <= '0;
            ov_reg     <= 1'b0;
            oslot_reg  <= '0;
            okind_reg  <= KIND_BIRTH;
            ox_reg     <= '0;
            oy_reg     <= '0;
            otime_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            addr_reg   <= addr_next;
            ek_reg     <= ek_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            now_reg    <= now_next;
            latest_reg <= latest_next;
            live_reg   <= live_next;
            ov_reg     <= ov_next;
            oslot_reg  <= oslot_next;
            okind_reg  <= okind_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            otime_reg  <= otime_next;
            olast_reg  <= olast_next;
        end
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = ov_reg;
    assign out_ch.out_slot = oslot_reg;
    assign out_ch.out_kind = okind_reg;
    assign out_ch.out_x    = ox_reg;
    assign out_ch.out_y    = oy_reg;
    assign out_ch.out_time = otime_reg;
    assign out_ch.last     = olast_reg;

endmodule

`default_nettype wire

// ----- sv/tef_cfg_regs.sv -----
// Touch event filter: slop and timeout configuration registers.
// Depends on tef_pkg.
`default_nettype none

module tef_cfg_regs
    import tef_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output tef_cfg_t                      cfg
);

    tef_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slop    <= SLOP_RESET;
            cfg_reg.timeout <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOP:    cfg_reg.slop    <= cfg_data[SLOP_BITS-1:0];
                CFG_TIMEOUT: cfg_reg.timeout <= cfg_data[TIMEOUT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/tef_slot_ram.sv -----
// Touch event filter: per-slot state memory, one write and one registered read port.
// Depends on tef_pkg.
`default_nettype none

module tef_slot_ram
    import tef_pkg::*;
#(
    parameter int DEPTH = DEF_SLOTS,
    parameter int AW    = 5,
    parameter int DW    = 8
)
(
    input  wire logic          clk,
    input  wire tef_ram_ctl_t  ctl,
    input  wire logic [DW-1:0] wr_data,
    output logic [DW-1:0]      rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/tef_checker.sv -----
// Touch event filter: port-level checks, bound to the top level.
// Depends on tef_pkg and touch_event_filter_top.
`default_nettype none

module tef_checker
    import tef_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [1:0]           in_opcode,
    input wire logic [SLOT_BITS-1:0] in_slot,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [SLOT_BITS-1:0] out_slot,
    input wire logic [1:0]           out_kind,
    input wire logic                 out_last
);

    // input ready drops after a report word for a real slot is accepted
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_REPORT)
            && ({1'b0, in_slot} < (SLOT_BITS + 1)'(SLOTS))
        |=> !in_ready)
        else $error("input still ready after a report word");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == KIND_BIRTH) || (out_kind == KIND_DEATH)
            || (out_kind == KIND_MOVE))
        else $error("undefined event kind");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_slot} < (SLOT_BITS + 1)'(SLOTS)))
        else $error("event for a slot beyond the table");

    // a stalled output word keeps its slot, kind and last flag until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_slot)
            && $stable(out_kind) && $stable(out_last))
        else $error("stalled output word changed");

endmodule

bind touch_event_filter_top tef_checker #(.SLOTS(SLOTS)) u_tef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .in_slot   (in_ch.slot),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_slot  (out_ch.out_slot),
    .out_kind  (out_ch.out_kind),
    .out_last  (out_ch.last)
);

`default_nettype wire
